// ===== hw/rtl/pwct_pkg.sv =====
// pwct_pkg: shared types and constants of the pulse-width code transmitter
// used by every module under hw/rtl; no dependencies
package pwct_pkg;

  // fixed field widths of the channels
  localparam int unsigned CodeW     = 64;
  localparam int unsigned CountW    = 7;
  localparam int unsigned OutDurW   = 16;
  localparam int unsigned RegIdxW   = 3;

  // parameter defaults
  localparam int unsigned MaxCodeBitsDef  = 64;
  localparam int unsigned DurationBitsDef = 16;

  // timing register reset values, microseconds
  localparam int unsigned SyncFirstRst  = 350;
  localparam int unsigned SyncSecondRst = 10850;
  localparam int unsigned ZeroFirstRst  = 350;
  localparam int unsigned ZeroSecondRst = 1050;
  localparam int unsigned OneFirstRst   = 1050;
  localparam int unsigned OneSecondRst  = 350;

  typedef enum logic [RegIdxW-1:0] {
    REG_SYNC_FIRST  = 3'd0,
    REG_SYNC_SECOND = 3'd1,
    REG_ZERO_FIRST  = 3'd2,
    REG_ZERO_SECOND = 3'd3,
    REG_ONE_FIRST   = 3'd4,
    REG_ONE_SECOND  = 3'd5,
    REG_INVERT      = 3'd6
  } pwct_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_ALIGN = 2'd1,
    ST_EMIT  = 2'd2
  } pwct_state_e;

  // sequencer commands to the shift unit
  typedef struct packed {
    logic load;
    logic shift;
  } pwct_shift_ctrl_t;

endpackage

// ===== hw/rtl/pulse_width_code_transmitter_core.sv =====
// Pulse-width code transmitter. Each accepted item (code_word, bit_count)
// produces max(n,1) results, n being bit_count saturated to MAX_CODE_BITS:
// the first result carries the sync pair, each result one data bit pair
// (none when n is 0), most significant bit first. A single shift register,
// under a small sequencer, first moves bit n-1 to its top one position per
// cycle (none when n is 0), then hands out one bit per result transfer.
// The input is not ready until the last result is taken. Configuration
// writes are always ready and take effect on the next cycle; write them
// only while no frame is in flight.
module pulse_width_code_transmitter_core #(
  parameter int unsigned MAX_CODE_BITS = pwct_pkg::MaxCodeBitsDef,
  parameter int unsigned DURATION_BITS = pwct_pkg::DurationBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [pwct_pkg::CodeW-1:0]    code_word_i,
  input  logic [pwct_pkg::CountW-1:0]   bit_count_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          sync_present_o,
  output logic [pwct_pkg::OutDurW-1:0]  sync_first_us_o,
  output logic [pwct_pkg::OutDurW-1:0]  sync_second_us_o,
  output logic                          bit_present_o,
  output logic                          bit_value_o,
  output logic [pwct_pkg::OutDurW-1:0]  bit_first_us_o,
  output logic [pwct_pkg::OutDurW-1:0]  bit_second_us_o,
  output logic                          first_is_mark_o,
  output logic                          last_pair_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pwct_pkg::RegIdxW-1:0]  cfg_index_i,
  input  logic [DURATION_BITS-1:0]      cfg_data_i
);
  import pwct_pkg::*;

  pwct_shift_ctrl_t     shift_ctrl;
  logic                 msb;
  logic                 first;
  logic                 has_bits;
  logic [OutDurW-1:0]   sync_first, sync_second;
  logic [OutDurW-1:0]   zero_first, zero_second;
  logic [OutDurW-1:0]   one_first, one_second;
  logic                 invert;

  assign cfg_ready_o = 1'b1;

  pwct_regs #(
    .DURATION_BITS (DURATION_BITS)
  ) u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i & cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .sync_first_o  (sync_first),
    .sync_second_o (sync_second),
    .zero_first_o  (zero_first),
    .zero_second_o (zero_second),
    .one_first_o   (one_first),
    .one_second_o  (one_second),
    .invert_o      (invert)
  );

  pwct_shift #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_shift (
    .clk_i       (clk_i),
    .ctrl_i      (shift_ctrl),
    .code_word_i (code_word_i),
    .msb_o       (msb)
  );

  pwct_seq #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .bit_count_i (bit_count_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .first_o     (first),
    .has_bits_o  (has_bits),
    .last_o      (last_pair_o),
    .ctrl_o      (shift_ctrl)
  );

  assign sync_present_o   = first;
  assign sync_first_us_o  = first ? sync_first : '0;
  assign sync_second_us_o = first ? sync_second : '0;
  assign bit_present_o    = has_bits;
  assign bit_value_o      = has_bits & msb;
  assign bit_first_us_o   = !has_bits ? '0 : (msb ? one_first : zero_first);
  assign bit_second_us_o  = !has_bits ? '0 : (msb ? one_second : zero_second);
  assign first_is_mark_o  = !invert;

endmodule

// ===== hw/rtl/pwct_regs.sv =====
// pwct_regs: timing and level configuration registers
// depends on pwct_pkg
module pwct_regs #(
  parameter int unsigned DURATION_BITS = pwct_pkg::DurationBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pwct_pkg::RegIdxW-1:0]  cfg_index_i,
  input  logic [DURATION_BITS-1:0]      cfg_data_i,
  output logic [pwct_pkg::OutDurW-1:0]  sync_first_o,
  output logic [pwct_pkg::OutDurW-1:0]  sync_second_o,
  output logic [pwct_pkg::OutDurW-1:0]  zero_first_o,
  output logic [pwct_pkg::OutDurW-1:0]  zero_second_o,
  output logic [pwct_pkg::OutDurW-1:0]  one_first_o,
  output logic [pwct_pkg::OutDurW-1:0]  one_second_o,
  output logic                          invert_o
);
  import pwct_pkg::*;

  localparam int unsigned ExtW = DURATION_BITS + OutDurW;

  logic [DURATION_BITS-1:0] sync_first_q, sync_second_q;
  logic [DURATION_BITS-1:0] zero_first_q, zero_second_q;
  logic [DURATION_BITS-1:0] one_first_q, one_second_q;
  logic                     invert_q;

  logic [ExtW-1:0] sync_first_ext, sync_second_ext;
  logic [ExtW-1:0] zero_first_ext, zero_second_ext;
  logic [ExtW-1:0] one_first_ext, one_second_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= DURATION_BITS'(SyncFirstRst);
      sync_second_q <= DURATION_BITS'(SyncSecondRst);
      zero_first_q  <= DURATION_BITS'(ZeroFirstRst);
      zero_second_q <= DURATION_BITS'(ZeroSecondRst);
      one_first_q   <= DURATION_BITS'(OneFirstRst);
      one_second_q  <= DURATION_BITS'(OneSecondRst);
      invert_q      <= 1'b0;
    end else if (cfg_we_i) begin
      case (pwct_reg_e'(cfg_index_i))
        REG_SYNC_FIRST:  sync_first_q  <= cfg_data_i;
        REG_SYNC_SECOND: sync_second_q <= cfg_data_i;
        REG_ZERO_FIRST:  zero_first_q  <= cfg_data_i;
        REG_ZERO_SECOND: zero_second_q <= cfg_data_i;
        REG_ONE_FIRST:   one_first_q   <= cfg_data_i;
        REG_ONE_SECOND:  one_second_q  <= cfg_data_i;
        REG_INVERT:      invert_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // zero-extend first so narrow durations still give a 16-bit field
  assign sync_first_ext  = {{OutDurW{1'b0}}, sync_first_q};
  assign sync_second_ext = {{OutDurW{1'b0}}, sync_second_q};
  assign zero_first_ext  = {{OutDurW{1'b0}}, zero_first_q};
  assign zero_second_ext = {{OutDurW{1'b0}}, zero_second_q};
  assign one_first_ext   = {{OutDurW{1'b0}}, one_first_q};
  assign one_second_ext  = {{OutDurW{1'b0}}, one_second_q};

  assign sync_first_o  = sync_first_ext[OutDurW-1:0];
  assign sync_second_o = sync_second_ext[OutDurW-1:0];
  assign zero_first_o  = zero_first_ext[OutDurW-1:0];
  assign zero_second_o = zero_second_ext[OutDurW-1:0];
  assign one_first_o   = one_first_ext[OutDurW-1:0];
  assign one_second_o  = one_second_ext[OutDurW-1:0];
  assign invert_o      = invert_q;

endmodule

// ===== hw/rtl/pwct_shift.sv =====
// pwct_shift: code word shift register, one bit per step toward the msb
// depends on pwct_pkg
module pwct_shift #(
  parameter int unsigned MAX_CODE_BITS = pwct_pkg::MaxCodeBitsDef
) (
  input  logic                            clk_i,
  input  pwct_pkg::pwct_shift_ctrl_t      ctrl_i,
  input  logic [pwct_pkg::CodeW-1:0]      code_word_i,
  output logic                            msb_o
);
  import pwct_pkg::*;

  logic [MAX_CODE_BITS-1:0] sreg_q, sreg_d;

  always_comb begin
    sreg_d = sreg_q;
    if (ctrl_i.load) begin
      sreg_d = code_word_i[MAX_CODE_BITS-1:0];
    end else if (ctrl_i.shift) begin
      sreg_d = sreg_q << 1;
    end
  end

  always_ff @(posedge clk_i) begin
    sreg_q <= sreg_d;
  end

  assign msb_o = sreg_q[MAX_CODE_BITS-1];

endmodule

// ===== hw/rtl/pwct_seq.sv =====
// pwct_seq: frame sequencer, aligns the code word then steps through its bits
// depends on pwct_pkg
module pwct_seq #(
  parameter int unsigned MAX_CODE_BITS = pwct_pkg::MaxCodeBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [pwct_pkg::CountW-1:0]   bit_count_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          first_o,
  output logic                          has_bits_o,
  output logic                          last_o,
  output pwct_pkg::pwct_shift_ctrl_t    ctrl_o
);
  import pwct_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_CODE_BITS + 1);

  pwct_state_e      state_q, state_d;
  logic [CntW-1:0]  rem_q, rem_d;
  logic [CntW-1:0]  pad_q, pad_d;
  logic             first_q, first_d;
  logic             zero_q, zero_d;
  logic [CntW-1:0]  count_sat;
  logic             last;

  // counts above the shift register depth saturate
  assign count_sat = (bit_count_i > CountW'(MAX_CODE_BITS)) ? CntW'(MAX_CODE_BITS)
                                                            : CntW'(bit_count_i);
  assign last = (rem_q <= CntW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rem_q   <= '0;
      pad_q   <= '0;
      first_q <= 1'b0;
      zero_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rem_q   <= rem_d;
      pad_q   <= pad_d;
      first_q <= first_d;
      zero_q  <= zero_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    rem_d        = rem_q;
    pad_d        = pad_q;
    first_d      = first_q;
    zero_d       = zero_q;
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    ctrl_o.load  = 1'b0;
    ctrl_o.shift = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          rem_d       = count_sat;
          zero_d      = (count_sat == '0);
          // move bit n-1 up to the msb; nothing to align when no bits are sent
          pad_d       = (count_sat == '0) ? '0 : CntW'(MAX_CODE_BITS) - count_sat;
          first_d     = 1'b1;
          state_d     = ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        if (pad_q == '0) begin
          state_d = ST_EMIT;
        end else begin
          ctrl_o.shift = 1'b1;
          pad_d        = pad_q - CntW'(1);
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (last) begin
            state_d = ST_IDLE;
          end else begin
            ctrl_o.shift = 1'b1;
            rem_d        = rem_q - CntW'(1);
            first_d      = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign first_o    = first_q;
  assign has_bits_o = !zero_q;
  assign last_o     = last;

endmodule

// ===== hw/rtl/pwct_chk.sv =====
// pwct_chk: port-level checks of the pulse-width code transmitter over time
// depends on pwct_pkg; bound to pulse_width_code_transmitter_core below
module pwct_chk (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_o,
  input  logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  logic                          sync_present_o,
  input  logic [pwct_pkg::OutDurW-1:0]  sync_first_us_o,
  input  logic [pwct_pkg::OutDurW-1:0]  sync_second_us_o,
  input  logic                          bit_present_o,
  input  logic [pwct_pkg::OutDurW-1:0]  bit_first_us_o,
  input  logic [pwct_pkg::OutDurW-1:0]  bit_second_us_o,
  input  logic                          last_pair_o
);
  import pwct_pkg::*;

  // one frame at a time: no input taken while a result is pending
  a_busy_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while a result is pending");

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input ready right after a transfer");

  // results after the first carry no sync and follow with no gap
  a_next_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_pair_o) |=> (out_valid_o && !sync_present_o))
    else $error("frame broken between pairs");

  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_pair_o) |=> (!out_valid_o && in_ready_o))
    else $error("no return to idle after the last pair");

  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((sync_present_o || (sync_first_us_o == '0 && sync_second_us_o == '0))
      && (bit_present_o || (bit_first_us_o == '0 && bit_second_us_o == '0))))
    else $error("absent pair with nonzero durations");

endmodule

bind pulse_width_code_transmitter_core pwct_chk u_chk (.*);
